/* sv/u2u8_pkg.sv */
// types, constants and helper functions shared by the utf16le to utf8 transcoder
// no dependencies

package u2u8_pkg;

    localparam logic [7:0] BYTE_EF = 8'hEF;
    localparam logic [7:0] BYTE_BB = 8'hBB;
    localparam logic [7:0] BYTE_BF = 8'hBF;
    localparam logic [7:0] BYTE_FF = 8'hFF;
    localparam logic [7:0] BYTE_FE = 8'hFE;

    localparam logic [15:0] SURR_HIGH_MIN = 16'hD800;
    localparam logic [15:0] SURR_HIGH_MAX = 16'hDBFF;
    localparam logic [15:0] SURR_LOW_MIN  = 16'hDC00;
    localparam logic [15:0] SURR_LOW_MAX  = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE     = 21'h10000;
    localparam logic [5:0]  SURR_HIGH_TAG = 6'b110110;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);

    typedef enum logic [1:0] {
        MODE_SNIFF,
        MODE_PASS,
        MODE_UTF16
    } mode_t;

    // raw slots carry 1 to 3 bytes packed low byte first, a code point slot 21 bits
    typedef enum logic [2:0] {
        SLOT_NONE,
        SLOT_RAW1,
        SLOT_RAW2,
        SLOT_RAW3,
        SLOT_CP
    } slot_kind_t;

    typedef struct packed {
        slot_kind_t  kind;
        logic [23:0] value;
    } slot_t;

    typedef struct packed {
        slot_t s0;
        slot_t s1;
        logic  last;
    } job_t;

    function automatic logic [2:0] slot_len(slot_t s);
        logic [2:0] n;
        n = 3'd0;
        case (s.kind)
            SLOT_RAW1: n = 3'd1;
            SLOT_RAW2: n = 3'd2;
            SLOT_RAW3: n = 3'd3;
            SLOT_CP:
            begin
                if (s.value[20:7] == '0)
                    n = 3'd1;
                else if (s.value[20:11] == '0)
                    n = 3'd2;
                else if (s.value[20:16] == '0)
                    n = 3'd3;
                else
                    n = 3'd4;
            end
            default: n = 3'd0;
        endcase
        return n;
    endfunction

    function automatic logic [7:0] slot_byte(slot_t s, logic [1:0] k);
        logic [20:0] cp;
        logic [2:0]  n;
        logic [7:0]  b;
        cp = s.value[20:0];
        n  = slot_len(s);
        b  = 8'h00;
        if (s.kind == SLOT_CP)
        begin
            case (n)
                3'd1: b = {1'b0, cp[6:0]};
                3'd2: b = (k == 2'd0) ? {3'b110, cp[10:6]} : {2'b10, cp[5:0]};
                3'd3:
                begin
                    case (k)
                        2'd0:    b = {4'b1110, cp[15:12]};
                        2'd1:    b = {2'b10, cp[11:6]};
                        default: b = {2'b10, cp[5:0]};
                    endcase
                end
                default:
                begin
                    case (k)
                        2'd0:    b = {5'b11110, cp[20:18]};
                        2'd1:    b = {2'b10, cp[17:12]};
                        2'd2:    b = {2'b10, cp[11:6]};
                        default: b = {2'b10, cp[5:0]};
                    endcase
                end
            endcase
        end
        else
        begin
            case (k)
                2'd0:    b = s.value[7:0];
                2'd1:    b = s.value[15:8];
                default: b = s.value[23:16];
            endcase
        end
        return b;
    endfunction

endpackage

/* sv/u2u8_front.sv */
// front end: header sniffing, utf16 unit pairing and surrogate joining
// depends on u2u8_pkg; emits one job per accepted byte that yields output or ends a stream

module u2u8_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              take,
    input  logic [7:0]        in_byte,
    input  logic              in_last,
    output logic              push,
    output u2u8_pkg::job_t    push_job
);

    u2u8_pkg::mode_t mode_reg, mode_next;
    logic [15:0] hdr_reg, hdr_next;
    logic [1:0]  hcnt_reg, hcnt_next;
    logic [7:0]  low_reg, low_next;
    logic        half_reg, half_next;
    logic [9:0]  hs_reg, hs_next;
    logic        hs_held_reg, hs_held_next;

    logic [15:0]        unit;
    logic [20:0]        held_cp;
    u2u8_pkg::slot_t    s0, s1;

    assign unit    = {in_byte, low_reg};
    assign held_cp = {5'b0, u2u8_pkg::SURR_HIGH_TAG, hs_reg};

    always_comb
    begin
        mode_next    = mode_reg;
        hdr_next     = hdr_reg;
        hcnt_next    = hcnt_reg;
        low_next     = low_reg;
        half_next    = half_reg;
        hs_next      = hs_reg;
        hs_held_next = hs_held_reg;
        s0           = '{kind: u2u8_pkg::SLOT_NONE, value: '0};
        s1           = '{kind: u2u8_pkg::SLOT_NONE, value: '0};

        case (mode_reg)
            u2u8_pkg::MODE_SNIFF:
            begin
                case (hcnt_reg)
                    2'd0:
                    begin
                        if (in_byte == u2u8_pkg::BYTE_EF || in_byte == u2u8_pkg::BYTE_FF)
                        begin
                            hdr_next  = {8'h00, in_byte};
                            hcnt_next = 2'd1;
                        end
                        else
                        begin
                            mode_next = u2u8_pkg::MODE_PASS;
                            s0 = '{kind: u2u8_pkg::SLOT_RAW1, value: {16'h0000, in_byte}};
                        end
                    end
                    2'd1:
                    begin
                        if (hdr_reg[7:0] == u2u8_pkg::BYTE_FF && in_byte == u2u8_pkg::BYTE_FE)
                        begin
                            mode_next = u2u8_pkg::MODE_UTF16;
                            hcnt_next = 2'd0;
                            hdr_next  = '0;
                        end
                        else if (hdr_reg[7:0] == u2u8_pkg::BYTE_EF &&
                                 in_byte == u2u8_pkg::BYTE_BB)
                        begin
                            hdr_next  = {in_byte, hdr_reg[7:0]};
                            hcnt_next = 2'd2;
                        end
                        else
                        begin
                            mode_next = u2u8_pkg::MODE_PASS;
                            s0 = '{kind: u2u8_pkg::SLOT_RAW2,
                                   value: {8'h00, in_byte, hdr_reg[7:0]}};
                            hcnt_next = 2'd0;
                            hdr_next  = '0;
                        end
                    end
                    default:
                    begin
                        mode_next = u2u8_pkg::MODE_PASS;
                        if (in_byte != u2u8_pkg::BYTE_BF)
                            s0 = '{kind: u2u8_pkg::SLOT_RAW3, value: {in_byte, hdr_reg}};
                        hcnt_next = 2'd0;
                        hdr_next  = '0;
                    end
                endcase
            end
            u2u8_pkg::MODE_UTF16:
            begin
                if (half_reg)
                begin
                    half_next = 1'b0;
                    low_next  = '0;
                    if (hs_held_reg && unit >= u2u8_pkg::SURR_LOW_MIN &&
                        unit <= u2u8_pkg::SURR_LOW_MAX)
                    begin
                        // surrogate pair joins into a supplementary code point
                        s0 = '{kind: u2u8_pkg::SLOT_CP,
                               value: {3'b0, u2u8_pkg::SUPP_BASE + {1'b0, hs_reg, unit[9:0]}}};
                        hs_held_next = 1'b0;
                        hs_next      = '0;
                    end
                    else
                    begin
                        if (hs_held_reg)
                            s0 = '{kind: u2u8_pkg::SLOT_CP, value: {3'b0, held_cp}};
                        if (unit >= u2u8_pkg::SURR_HIGH_MIN && unit <= u2u8_pkg::SURR_HIGH_MAX)
                        begin
                            hs_next      = unit[9:0];
                            hs_held_next = 1'b1;
                        end
                        else
                        begin
                            hs_held_next = 1'b0;
                            hs_next      = '0;
                            if (hs_held_reg)
                                s1 = '{kind: u2u8_pkg::SLOT_CP, value: {8'h00, unit}};
                            else
                                s0 = '{kind: u2u8_pkg::SLOT_CP, value: {8'h00, unit}};
                        end
                    end
                end
                else
                begin
                    low_next  = in_byte;
                    half_next = 1'b1;
                end
            end
            default:
            begin
                s0 = '{kind: u2u8_pkg::SLOT_RAW1, value: {16'h0000, in_byte}};
            end
        endcase

        // end of stream: flush what is still held
        if (in_last)
        begin
            if (mode_next == u2u8_pkg::MODE_SNIFF)
            begin
                if (hcnt_next == 2'd1)
                    s0 = '{kind: u2u8_pkg::SLOT_RAW1, value: {16'h0000, hdr_next[7:0]}};
                else if (hcnt_next == 2'd2)
                    s0 = '{kind: u2u8_pkg::SLOT_RAW2, value: {8'h00, hdr_next}};
            end
            else if (mode_next == u2u8_pkg::MODE_UTF16 && hs_held_next)
            begin
                if (s0.kind == u2u8_pkg::SLOT_NONE)
                    s0 = '{kind: u2u8_pkg::SLOT_CP,
                           value: {3'b0, 5'b0, u2u8_pkg::SURR_HIGH_TAG, hs_next}};
                else
                    s1 = '{kind: u2u8_pkg::SLOT_CP,
                           value: {3'b0, 5'b0, u2u8_pkg::SURR_HIGH_TAG, hs_next}};
            end
        end
    end

    assign push          = take && (s0.kind != u2u8_pkg::SLOT_NONE || in_last);
    assign push_job.s0   = s0;
    assign push_job.s1   = s1;
    assign push_job.last = in_last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= u2u8_pkg::MODE_SNIFF;
            hdr_reg     <= '0;
            hcnt_reg    <= '0;
            low_reg     <= '0;
            half_reg    <= 1'b0;
            hs_reg      <= '0;
            hs_held_reg <= 1'b0;
        end
        else if (take)
        begin
            if (in_last)
            begin
                mode_reg    <= u2u8_pkg::MODE_SNIFF;
                hdr_reg     <= '0;
                hcnt_reg    <= '0;
                low_reg     <= '0;
                half_reg    <= 1'b0;
                hs_reg      <= '0;
                hs_held_reg <= 1'b0;
            end
            else
            begin
                mode_reg    <= mode_next;
                hdr_reg     <= hdr_next;
                hcnt_reg    <= hcnt_next;
                low_reg     <= low_next;
                half_reg    <= half_next;
                hs_reg      <= hs_next;
                hs_held_reg <= hs_held_next;
            end
        end
    end

endmodule

/* sv/u2u8_queue.sv */
// two-entry job queue between the front and back ends
// depends on u2u8_pkg

module u2u8_queue (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  u2u8_pkg::job_t    push_job,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output u2u8_pkg::job_t    head_job
);

    u2u8_pkg::job_t mem [u2u8_pkg::QUEUE_DEPTH];

    logic [u2u8_pkg::QUEUE_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [u2u8_pkg::QUEUE_PTR_W:0]   count_reg, count_next;

    assign full       = (count_reg == (u2u8_pkg::QUEUE_PTR_W + 1)'(u2u8_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_job   = mem[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_job;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= (wr_ptr_reg ==
                               (u2u8_pkg::QUEUE_PTR_W)'(u2u8_pkg::QUEUE_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= (rd_ptr_reg ==
                               (u2u8_pkg::QUEUE_PTR_W)'(u2u8_pkg::QUEUE_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            count_reg <= count_next;
        end
    end

endmodule

/* sv/u2u8_back.sv */
// back end: serializes one job into utf8 or raw bytes, one per cycle while out_stall is low
// depends on u2u8_pkg; holds the output register

module u2u8_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              head_valid,
    input  u2u8_pkg::job_t    head_job,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              byte_valid,
    output logic              run_last,
    output logic              stream_end
);

    logic       slot_reg, slot_next;
    logic [1:0] idx_reg, idx_next;
    logic       out_valid_reg;
    logic [7:0] byte_reg;
    logic       bvalid_reg, run_last_reg, stream_end_reg;

    u2u8_pkg::slot_t cur;
    logic [2:0]      cur_len;
    logic            cur_empty, slot_end, more_slot, job_done, load;

    assign cur       = slot_reg ? head_job.s1 : head_job.s0;
    assign cur_len   = u2u8_pkg::slot_len(cur);
    assign cur_empty = (cur.kind == u2u8_pkg::SLOT_NONE);
    assign slot_end  = ({1'b0, idx_reg} + 3'd1 == cur_len);
    assign more_slot = !slot_reg && head_job.s1.kind != u2u8_pkg::SLOT_NONE;
    assign job_done  = cur_empty || (slot_end && !more_slot);
    assign load      = head_valid && (!out_valid_reg || !out_stall);
    assign pop       = load && job_done;

    always_comb
    begin
        slot_next = slot_reg;
        idx_next  = idx_reg;
        if (load)
        begin
            if (job_done)
            begin
                slot_next = 1'b0;
                idx_next  = '0;
            end
            else if (slot_end)
            begin
                slot_next = 1'b1;
                idx_next  = '0;
            end
            else
                idx_next = idx_reg + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            slot_reg <= slot_next;
            idx_reg  <= idx_next;
            if (load)
                out_valid_reg <= 1'b1;
            else if (!out_stall)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            byte_reg       <= cur_empty ? 8'h00 : u2u8_pkg::slot_byte(cur, idx_reg);
            bvalid_reg     <= !cur_empty;
            run_last_reg   <= job_done;
            stream_end_reg <= job_done && head_job.last;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = byte_reg;
    assign byte_valid = bvalid_reg;
    assign run_last   = run_last_reg;
    assign stream_end = stream_end_reg;

    // byte index stays inside the slot being sent
    a_idx_in_slot: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && !cur_empty |-> ({1'b0, idx_reg} < cur_len))
        else $error("byte index beyond slot length");

    // second slot is only visited when it holds something
    a_slot1_used: assert property (@(posedge clk) disable iff (!rst_n)
        head_valid && slot_reg |-> head_job.s1.kind != u2u8_pkg::SLOT_NONE)
        else $error("second slot visited while empty");

    // stream end always closes the run of its item
    a_end_closes_run: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && stream_end_reg |-> run_last_reg)
        else $error("stream end without run last");

    // a bare marker only appears at the stream end
    a_bare_is_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !bvalid_reg |-> stream_end_reg && byte_reg == 8'h00)
        else $error("bare marker outside stream end");

endmodule

/* sv/utf16le_to_utf8_transcoder.sv */
// Byte stream transcoder: strips a utf8 bom, passes plain streams through and
// converts utf16le streams (ff fe mark) to utf8.
// Input channel: in_valid / in_stall with in_byte, in_last (one raw byte per
// transfer, in_last on the final byte of a stream).
// Output channel: out_valid / out_stall with out_byte, byte_valid, run_last,
// stream_end. Each input byte yields zero to six output transfers; run_last
// marks the final one of an input byte, stream_end the final one of a stream.
// A stream ending with no pending data gives one transfer with byte_valid low.
// The front end takes one input byte per cycle while the queue is not full, and
// the back end sends one output byte per cycle while out_stall is low; a byte
// with no result costs the back end nothing.
// A two-entry job queue sits between front and back, so in_stall rises only
// when that queue is full; out_stall holds the output register and backs up
// the queue. Reset (rst_n low, asynchronous) empties the queue and output and
// returns to header sniffing; every end of stream does the same for the front.
// depends on u2u8_pkg, u2u8_front, u2u8_queue, u2u8_back

module utf16le_to_utf8_transcoder (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       in_last,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       byte_valid,
    output logic       run_last,
    output logic       stream_end
);

    logic           take, push, full, pop, head_valid;
    u2u8_pkg::job_t push_job, head_job;

    assign in_stall = full;
    assign take     = in_valid && !full;

    u2u8_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .take     (take),
        .in_byte  (in_byte),
        .in_last  (in_last),
        .push     (push),
        .push_job (push_job)
    );

    u2u8_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_job   (push_job),
        .full       (full),
        .pop        (pop),
        .head_valid (head_valid),
        .head_job   (head_job)
    );

    u2u8_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head_valid (head_valid),
        .head_job   (head_job),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .run_last   (run_last),
        .stream_end (stream_end)
    );

endmodule
